// File: hdl/chkv_pkg.sv
// Shared types and constants for the chained hash key/value table.
package chkv_pkg;
  localparam int Buckets   = 1024;
  localparam int PoolSlots = 256;
  localparam int BW = $clog2(Buckets);
  localparam int SW = $clog2(PoolSlots);
  localparam int LW = SW + 1;          // slot index plus end-of-chain code
  localparam logic [LW-1:0] NIL = LW'(PoolSlots);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_INVALID  = 3'd1,
    ST_DUP      = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  // Slot store request from the sequencer.
  typedef struct packed {
    logic            rd_en;
    logic [SW-1:0]   rd_addr;
    logic            wr_all;    // write key, value and link
    logic            wr_link;   // write link only
    logic [SW-1:0]   wr_addr;
    logic [31:0]     wr_key;
    logic [31:0]     wr_val;
    logic [LW-1:0]   wr_lnk;
  } slot_req_t;

  typedef struct packed {
    logic [31:0]   key;
    logic [31:0]   val;
    logic [LW-1:0] lnk;
  } slot_rd_t;
endpackage

// File: hdl/chkv_slot_store.sv
// Slot memory: key, value and chain link for every pool slot.
module chkv_slot_store (
  input  logic              clk,
  input  chkv_pkg::slot_req_t req,
  output chkv_pkg::slot_rd_t  rd
);
  import chkv_pkg::*;
  logic [31:0]   keys_m [PoolSlots];
  logic [31:0]   vals_m [PoolSlots];
  logic [LW-1:0] lnks_m [PoolSlots];

  always_ff @(posedge clk) begin
    if (req.wr_all) begin
      keys_m[req.wr_addr] <= req.wr_key;
      vals_m[req.wr_addr] <= req.wr_val;
    end
    if (req.wr_all || req.wr_link) lnks_m[req.wr_addr] <= req.wr_lnk;
    if (req.rd_en) begin
      rd.key <= keys_m[req.rd_addr];
      rd.val <= vals_m[req.rd_addr];
      rd.lnk <= lnks_m[req.rd_addr];
    end
  end
endmodule

// File: hdl/chained_hash_key_value_table_unit.sv
// Top level of the chained hash key/value table.
// One request (insert, lookup or remove) is taken when start is high and busy
// is low; its single result appears on the out_ ports for one cycle with
// out_valid high and cannot be held off. A request reads the bucket head,
// then walks the chain with one slot memory read and one compare per entry,
// the matching entry included; an insert that finds no duplicate then goes
// to the free stack. After reset the block sweeps all 1024 buckets of the
// bucket head memory, one bucket per cycle, with busy high.
module chained_hash_key_value_table_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_key,
  input  logic [31:0] in_value,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [31:0] out_value_out,
  output logic [7:0]  out_entry_slot,
  output logic [8:0]  out_item_count
);
  import chkv_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_HEAD  = 8'b0000_0100,  // head registered; free stack read in flight
    S_HCHK  = 8'b0000_1000,  // head available
    S_SLOT  = 8'b0001_0000,  // slot read data registered
    S_CMP   = 8'b0010_0000,  // compare key of current slot
    S_FREE  = 8'b0100_0000,  // take a free slot unless full, link it in as head
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // bucket head memory and free slot stack
  logic [LW-1:0] heads_m [Buckets];
  logic [SW-1:0] free_m  [PoolSlots];
  logic [LW-1:0] head_rd_r;
  logic [SW-1:0] free_rd_r;

  logic [BW-1:0] clr_r;
  logic [1:0]    cmd_r;
  logic [31:0]   key_r, val_r;
  logic [LW-1:0] cur_r, prev_r;
  logic [LW:0]   steps_r;
  logic [LW-1:0] total_r;
  logic [SW:0]   frinit_r;   // free stack entries below this were written

  logic [2:0]  st_r;
  logic [31:0] vo_r;
  logic [SW-1:0] so_r;
  logic        ov_r;

  slot_req_t req;
  slot_rd_t  srd;

  chkv_slot_store u_store (.clk(clk), .req(req), .rd(srd));

  wire [BW-1:0] bkt = key_r[BW-1:0];
  wire          hit = (srd.key == key_r);
  wire [SW-1:0] tot_i = total_r[SW-1:0];
  // free stack entries never written hold their own index
  wire [SW-1:0] free_val = ({1'b0, tot_i} < frinit_r) ? free_rd_r : tot_i;

  // head memory port controls
  logic          h_we;
  logic [LW-1:0] h_wd;
  logic [BW-1:0] h_wa;

  always_comb begin
    state_nxt = state_r;
    req = '0;
    req.wr_addr = cur_r[SW-1:0];
    req.rd_addr = cur_r[SW-1:0];
    req.wr_key  = key_r;
    req.wr_val  = val_r;
    req.wr_lnk  = srd.lnk;
    h_we = 1'b0;
    h_wd = NIL;
    h_wa = bkt;
    case (state_r)
      S_CLEAR: begin
        h_we = 1'b1;
        h_wa = clr_r;
        if (clr_r == BW'(Buckets - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: if (start) state_nxt = S_HEAD;
      S_HEAD: state_nxt = S_HCHK;
      S_HCHK: begin
        if (cmd_r == CMD_NONE || (cmd_r == CMD_INSERT && val_r == '0)) state_nxt = S_DONE;
        else if (head_rd_r == NIL) state_nxt = (cmd_r == CMD_INSERT) ? S_FREE : S_DONE;
        else begin
          req.rd_en = 1'b1;
          req.rd_addr = head_rd_r[SW-1:0];
          state_nxt = S_SLOT;
        end
      end
      S_SLOT: state_nxt = S_CMP;
      S_CMP: begin
        if (hit) begin
          if (cmd_r == CMD_REMOVE) begin
            if (prev_r == NIL) begin
              h_we = 1'b1;
              h_wd = srd.lnk;
            end else begin
              req.wr_link = 1'b1;
              req.wr_addr = prev_r[SW-1:0];
            end
          end
          state_nxt = S_DONE;
        end else if (srd.lnk == NIL || steps_r == (LW+1)'(PoolSlots - 1)) begin
          state_nxt = (cmd_r == CMD_INSERT) ? S_FREE : S_DONE;
        end else begin
          req.rd_en = 1'b1;
          req.rd_addr = srd.lnk[SW-1:0];
          state_nxt = S_SLOT;
        end
      end
      S_FREE: begin
        if (total_r == NIL) state_nxt = S_DONE;
        else begin
          req.wr_all = 1'b1;
          req.wr_addr = free_val;
          req.wr_lnk = head_rd_r;
          h_we = 1'b1;
          h_wd = {1'b0, free_val};
          state_nxt = S_DONE;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (h_we) heads_m[h_wa] <= h_wd;
    if (state_r == S_IDLE) head_rd_r <= heads_m[in_key[BW-1:0]];
    if (state_r == S_HEAD) free_rd_r <= free_m[tot_i];
    if (state_r == S_CMP && hit && cmd_r == CMD_REMOVE) free_m[tot_i - 1'b1] <= cur_r[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      total_r  <= '0;
      frinit_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= 1'b0;
      if (state_r == S_CLEAR) clr_r <= clr_r + 1'b1;
      case (state_r)
        S_IDLE: if (start) begin
          cmd_r <= in_command; key_r <= in_key; val_r <= in_value;
          prev_r <= NIL; steps_r <= '0;
          st_r <= ST_NOTFOUND; vo_r <= '0; so_r <= '0;
        end
        S_HCHK: begin
          cur_r <= head_rd_r;
          if (cmd_r == CMD_INSERT && val_r == '0) st_r <= ST_INVALID;
        end
        S_CMP: begin
          if (hit) begin
            case (cmd_r)
              CMD_INSERT: st_r <= ST_DUP;
              CMD_LOOKUP: begin st_r <= ST_OK; vo_r <= srd.val; end
              CMD_REMOVE: begin
                st_r <= ST_OK; vo_r <= srd.val; so_r <= cur_r[SW-1:0];
                total_r <= total_r - 1'b1;
                // entry total-1 gets written; mark everything up to it
                if (total_r - 1'b1 >= frinit_r) frinit_r <= total_r;
              end
              default: ;
            endcase
          end else begin
            prev_r <= cur_r;
            cur_r <= srd.lnk;
            steps_r <= steps_r + 1'b1;
          end
        end
        S_FREE: begin
          if (total_r == NIL) st_r <= ST_FULL;
          else begin
            st_r <= ST_OK; so_r <= free_val; total_r <= total_r + 1'b1;
          end
        end
        S_DONE: ov_r <= 1'b1;
        default: ;
      endcase
    end
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = ov_r;
  assign out_status     = st_r;
  assign out_value_out  = vo_r;
  assign out_entry_slot = 8'(so_r);
  assign out_item_count = 9'(total_r);
endmodule

// File: hdl/chkv_checker.sv
// Port-level checker for the chained hash key/value table.
module chkv_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [2:0] out_status,
  input logic [31:0] out_value_out,
  input logic [8:0] out_item_count
);
  import chkv_pkg::*;
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy not raised");
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$past(out_valid)) else $error("double result");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_FULL) else $error("bad status");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item_count <= 9'(PoolSlots)) else $error("count overflow");
  a_nf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_NOTFOUND) |-> out_value_out == '0) else $error("value on miss");
endmodule

bind chained_hash_key_value_table_unit chkv_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_status(out_status), .out_value_out(out_value_out), .out_item_count(out_item_count)
);
